// ===== rtl/pls_pkg.sv =====
// ============================================================================
// pls_pkg: shared types and constants for path length and segment speed
// Widths of the point differences, squares, root, divider and sums, plus the
// record that travels from the front part to the back part.
// ============================================================================
package pls_pkg;

    // Track geometry and counter range.
    localparam int COORD_BITS = 20;
    localparam int MAX_POINTS = 65536;
    localparam int IN_W       = 20;                       // port width of x_pos, y_pos
    localparam int CNT_W      = $clog2(MAX_POINTS);

    // Datapath widths. A coordinate difference fits COORD_BITS bits unsigned,
    // the sum of two squares one bit more than a square.
    localparam int DIFF_W = COORD_BITS;
    localparam int SQR_W  = 2 * DIFF_W;
    localparam int SQ_W   = SQR_W + 1;
    localparam int ROOT_W = COORD_BITS + 9;               // integer pairs plus 8 fraction bits
    localparam int RAD_W  = 2 * ROOT_W;

    // Result and accumulator widths.
    localparam int SPEED_W = 25;
    localparam int LEN_W   = 46;
    localparam int SSUM_W  = 41;

    // Division by 17 as a multiply by ceil(2^34 / 17) and a right shift by 34.
    // The result is exact for every dividend below 2^29.
    localparam int                 RECIP_W     = 30;
    localparam int                 SPEED_SHIFT = 34;
    localparam logic [RECIP_W-1:0] SPEED_RECIP = 30'd1010580541;
    localparam int                 MUL_W       = ROOT_W + RECIP_W;
    localparam int SPQ_W = ((MUL_W - SPEED_SHIFT) > SPEED_W) ? (MUL_W - SPEED_SHIFT) : SPEED_W;

    // Mean divider: dividend is the speed sum, divisor the step count.
    localparam int DIV_W      = SSUM_W;
    localparam int DVS_W      = CNT_W;
    localparam int DSTEP_W    = $clog2(DIV_W + 1);

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
    localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [SSUM_W-1:0]  SSUM_MAX  = {SSUM_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_POINTS - 1);

    // One classified point, as queued between the front and back parts.
    typedef struct packed {
        logic [DIFF_W-1:0] dx_abs;
        logic [DIFF_W-1:0] dy_abs;
        logic              has_step;
        logic              last;
    } pls_step_t;

endpackage

// ===== rtl/pls_front.sv =====
// ============================================================================
// pls_front: point intake and classification
// Accepts points, forms the absolute coordinate differences against the
// previous point of the track and queues them in a two-entry queue.
// ============================================================================
module pls_front
    import pls_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [IN_W-1:0]        x_pos,
    input  logic [IN_W-1:0]        y_pos,
    input  logic                   last_point,
    output logic                   q_valid,
    output pls_step_t              q_data,
    input  logic                   q_pop
);

    localparam int QDEPTH = 2;

    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                  have_prev_reg;
    pls_step_t             entry_reg [QDEPTH];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            cnt_reg;

    logic                  push;
    logic [COORD_BITS:0]   dx, dy, dx_neg, dy_neg;
    pls_step_t             new_entry;

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = entry_reg[rd_ptr_reg];

    // Differences taken one bit wider than a coordinate, then folded to magnitude.
    always_comb begin
        dx = {x_pos[COORD_BITS-1], x_pos[COORD_BITS-1:0]}
           - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        dy = {y_pos[COORD_BITS-1], y_pos[COORD_BITS-1:0]}
           - {prev_y_reg[COORD_BITS-1], prev_y_reg};
        dx_neg = ~dx + 1'b1;
        dy_neg = ~dy + 1'b1;
        new_entry.dx_abs   = dx[COORD_BITS] ? dx_neg[DIFF_W-1:0] : dx[DIFF_W-1:0];
        new_entry.dy_abs   = dy[COORD_BITS] ? dy_neg[DIFF_W-1:0] : dy[DIFF_W-1:0];
        new_entry.has_step = have_prev_reg;
        new_entry.last     = last_point;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (push) begin
                entry_reg[wr_ptr_reg] <= new_entry;
                wr_ptr_reg            <= ~wr_ptr_reg;
                if (last_point) begin
                    prev_x_reg    <= '0;
                    prev_y_reg    <= '0;
                    have_prev_reg <= 1'b0;
                end else begin
                    prev_x_reg    <= x_pos[COORD_BITS-1:0];
                    prev_y_reg    <= y_pos[COORD_BITS-1:0];
                    have_prev_reg <= 1'b1;
                end
            end
            if (q_pop && q_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !(q_pop && q_valid)) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (!push && q_pop && q_valid) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/pls_isqrt.sv =====
// ============================================================================
// pls_isqrt: digit-by-digit integer square root
// Returns floor(sqrt(s) * 256), one root bit per cycle.
// ============================================================================
module pls_isqrt
    import pls_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [ROOT_W+3:0]   ext, trial, diff;
    logic                fits;

    // Done rises in the same cycle that the last root bit shows on root.
    assign root = root_reg;
    assign done = done_reg;

    always_comb begin
        ext   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial = (ROOT_W+4)'({root_reg, 2'b01});
        fits  = (ext >= trial);
        diff  = ext - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ROOT_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // The radicand is scaled by 2^16 so the root carries 8 fraction bits.
            rad_reg  <= {(SQ_W+1)'(radicand), 16'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[ROOT_W+1:0] : ext[ROOT_W+1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/pls_div.sv =====
// ============================================================================
// pls_div: restoring divider, one quotient bit per cycle
// The dividend is loaded left aligned; the caller gives the number of steps.
// ============================================================================
module pls_div
    import pls_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [DVS_W-1:0]   divisor,
    input  logic [DSTEP_W-1:0] steps,
    output logic               done,
    output logic [DIV_W-1:0]   quotient,
    output logic [DVS_W-1:0]   remainder
);

    logic [DIV_W-1:0]   quo_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DSTEP_W-1:0] step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DVS_W:0]     trial, diff;
    logic               fits;

    // Done rises in the same cycle that the last quotient bit shows on quotient.
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && !start && (step_reg == DSTEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= steps;
            end else if (busy_reg) begin
                step_reg <= step_reg - DSTEP_W'(1);
                if (step_reg == DSTEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

endmodule

// ===== rtl/pls_back.sv =====
// ============================================================================
// pls_back: step length, speed and track summary
// Takes queued steps one at a time, runs square, root and divide, keeps the
// track sums and drives the result register.
// ============================================================================
module pls_back
    import pls_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  pls_step_t          q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SPEED_W-1:0] out_speed,
    output logic [LEN_W-1:0]   out_total,
    output logic [SPEED_W-1:0] out_avg,
    output logic               out_none,
    output logic               out_last
);

    typedef enum logic [8:0] {
        ST_IDLE        = 9'b000000001,
        ST_SQUARE      = 9'b000000010,
        ST_ROOT_GO     = 9'b000000100,
        ST_ROOT_WAIT   = 9'b000001000,
        ST_SPEED_MUL   = 9'b000010000,
        ST_SPEED_SHIFT = 9'b000100000,
        ST_FINISH      = 9'b001000000,
        ST_AVG_WAIT    = 9'b010000000,
        ST_OUTPUT      = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    pls_step_t          step_reg;
    logic [SQR_W-1:0]   sqx_reg, sqy_reg;
    logic [ROOT_W-1:0]  scaled_reg;
    logic [MUL_W-1:0]   mul_reg;
    logic [SPEED_W-1:0] speed_reg, avg_reg;
    logic               none_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LEN_W-1:0]   lsum_reg;
    logic [SSUM_W-1:0]  ssum_reg;

    logic               out_valid_reg;
    logic [SPEED_W-1:0] out_speed_reg, out_avg_reg;
    logic [LEN_W-1:0]   out_total_reg;
    logic               out_none_reg, out_last_reg;

    logic               root_start, root_done;
    logic [ROOT_W-1:0]  root_val;
    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_dividend, div_quo;
    logic [DVS_W-1:0]   div_divisor, div_rem;
    logic [DSTEP_W-1:0] div_steps;

    logic [ROOT_W+3:0]  len_x15;
    logic [SPQ_W-1:0]   speed_q;
    logic [SPEED_W-1:0] speed_sat;
    logic [LEN_W:0]     lsum_add;
    logic [SSUM_W:0]    ssum_add;
    logic [SSUM_W-1:0]  ssum_new;
    logic               round_up;
    logic               out_free, out_load;

    pls_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (SQ_W'(sqx_reg) + SQ_W'(sqy_reg)),
        .done     (root_done),
        .root     (root_val)
    );

    pls_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == ST_OUTPUT) && out_free;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    assign root_start = (state_reg == ST_ROOT_GO);
    assign div_start  = (state_reg == ST_FINISH) && step_reg.last && (count_reg != '0);

    // The mean is taken over the speed sum that already includes this step.
    assign div_dividend = step_reg.has_step ? ssum_new : ssum_reg;
    assign div_divisor  = DVS_W'(count_reg);
    assign div_steps    = DSTEP_W'(DIV_W);

    always_comb begin
        len_x15   = {root_val, 4'b0000} - (ROOT_W+4)'(root_val);
        // Speed: length*15/16 divided by 17 through the reciprocal product.
        speed_q   = SPQ_W'(mul_reg[MUL_W-1:SPEED_SHIFT]);
        speed_sat = (speed_q > SPQ_W'(SPEED_MAX)) ? SPEED_MAX : speed_q[SPEED_W-1:0];
        lsum_add  = {1'b0, lsum_reg} + (LEN_W+1)'(root_val);
        ssum_add  = {1'b0, ssum_reg} + (SSUM_W+1)'(speed_reg);
        ssum_new  = ssum_add[SSUM_W] ? SSUM_MAX : ssum_add[SSUM_W-1:0];
        // Round up only when twice the remainder exceeds the count.
        round_up  = ({div_rem, 1'b0} > {1'b0, DVS_W'(count_reg)});
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (q_valid) begin
                                state_next = q_data.has_step ? ST_SQUARE : ST_FINISH;
                            end
            ST_SQUARE:      state_next = ST_ROOT_GO;
            ST_ROOT_GO:     state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:   if (root_done) begin
                                state_next = ST_SPEED_MUL;
                            end
            ST_SPEED_MUL:   state_next = ST_SPEED_SHIFT;
            ST_SPEED_SHIFT: state_next = ST_FINISH;
            ST_FINISH:      state_next = div_start ? ST_AVG_WAIT : ST_OUTPUT;
            ST_AVG_WAIT:    if (div_done) begin
                                state_next = ST_OUTPUT;
                            end
            ST_OUTPUT:      if (out_free) begin
                                state_next = ST_IDLE;
                            end
            default:        state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lsum_reg      <= '0;
            ssum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ROOT_WAIT && root_done) begin
                lsum_reg <= lsum_add[LEN_W] ? LEN_MAX : lsum_add[LEN_W-1:0];
            end
            if (state_reg == ST_SPEED_SHIFT) begin
                if (count_reg != CNT_MAX) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (state_reg == ST_FINISH && step_reg.has_step) begin
                ssum_reg <= ssum_new;
            end
            if (out_load && step_reg.last) begin
                count_reg <= '0;
                lsum_reg  <= '0;
                ssum_reg  <= '0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            step_reg  <= q_data;
            speed_reg <= '0;
            avg_reg   <= '0;
            none_reg  <= 1'b0;
        end
        if (state_reg == ST_SQUARE) begin
            sqx_reg <= step_reg.dx_abs * step_reg.dx_abs;
            sqy_reg <= step_reg.dy_abs * step_reg.dy_abs;
        end
        if (state_reg == ST_ROOT_WAIT && root_done) begin
            // Length times 15/16, the first part of the scaling to ft/min.
            scaled_reg <= len_x15[ROOT_W+3:4];
        end
        if (state_reg == ST_SPEED_MUL) begin
            mul_reg <= scaled_reg * SPEED_RECIP;
        end
        if (state_reg == ST_SPEED_SHIFT) begin
            speed_reg <= speed_sat;
        end
        if (state_reg == ST_FINISH && step_reg.last && count_reg == '0) begin
            none_reg <= 1'b1;
        end
        if (state_reg == ST_AVG_WAIT && div_done) begin
            avg_reg <= div_quo[SPEED_W-1:0] + SPEED_W'(round_up);
        end
        if (out_load) begin
            out_speed_reg <= speed_reg;
            out_total_reg <= (step_reg.last && !none_reg) ? lsum_reg : '0;
            out_avg_reg   <= avg_reg;
            out_none_reg  <= none_reg;
            out_last_reg  <= step_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_speed = out_speed_reg;
    assign out_total = out_total_reg;
    assign out_avg   = out_avg_reg;
    assign out_none  = out_none_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/path_length_and_segment_speed.sv =====
// ============================================================================
// path_length_and_segment_speed: track length and per-step speed
// Streams track points in and gives one result beat per point: the speed of
// the step ending there and, on the last point, total length and mean speed.
// ============================================================================
//
//  Channel   Dir   Beat contents (lowest bit first)
//  s_        in    tdata: x_pos[19:0], y_pos[19:0]; tlast: last_point
//  m_        out   tdata: segment_speed[24:0], total_length_q8[45:0],
//                         average_speed[24:0]; tuser: no_segments;
//                  tlast: track_done
//
//  A point is taken while the two-entry queue behind the front part has room,
//  so up to two points are accepted while the back part is still working.
//  The back part handles one point at a time. A point with a step passes
//  these steps there: the fetch, the squares, the root start, the square
//  root (29 root bits, one per cycle, then its done flag), the reciprocal
//  multiply that divides by 17, storing the speed, the sums and loading the
//  result register. The last point of a track with steps adds the divider
//  run for the mean speed (41 quotient bits, then the divider's done flag).
//  The first point of a track has no step and goes from the fetch straight
//  to the sums and the result register.
//  Reset is synchronous and active low; it clears the queue, the sums, the
//  step count and the result valid flag. A stalled result beat holds in the
//  output register while the back part may fetch and start the next point.
//
module path_length_and_segment_speed
    import pls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Point stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // x_pos[19:0], y_pos[39:20]
    input  logic        s_tlast,   // last_point
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // segment_speed[24:0], total_length_q8[70:25],
                                   // average_speed[95:71]
    output logic        m_tuser,   // no_segments
    output logic        m_tlast    // track_done
);

    logic               q_valid, q_pop;
    pls_step_t          q_data;
    logic [SPEED_W-1:0] res_speed, res_avg;
    logic [LEN_W-1:0]   res_total;
    logic               res_none, res_last;

    // The front part keeps the previous point and turns each new point into
    // absolute x and y steps; it does not wait on the arithmetic while its queue has room.
    pls_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .x_pos      (s_tdata[19:0]),
        .y_pos      (s_tdata[39:20]),
        .last_point (s_tlast),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop)
    );

    // The back part computes length, speed and the track summary and owns
    // the result register.
    pls_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_speed (res_speed),
        .out_total (res_total),
        .out_avg   (res_avg),
        .out_none  (res_none),
        .out_last  (res_last)
    );

    assign m_tdata = {res_avg, res_total, res_speed};
    assign m_tuser = res_none;
    assign m_tlast = res_last;

    // A single-point flag only ever comes with the end of a track.
    a_none_only_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast
    ) else $error("no_segments set on a beat that does not end a track");

    // Summary fields stay zero on beats inside a track.
    a_summary_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[95:25] == '0)
    ) else $error("summary fields nonzero before the end of a track");

    // A single-point track reports no length, no mean and no speed.
    a_single_point: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0)
    ) else $error("single-point track reported nonzero results");

endmodule
